// File: sv/combined_tausworthe_rng_defines.svh
// assertion macros for the combined tausworthe generator
// used by the top level only, no other dependencies
`ifndef COMBINED_TAUSWORTHE_RNG_DEFINES_SVH
`define COMBINED_TAUSWORTHE_RNG_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CTAUS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("ctaus check failed");

// next-cycle implication, checked outside reset
`define CTAUS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("ctaus check failed");

`endif

// File: sv/ctaus_pkg.sv
// shared types, constants and the component update function
// no dependencies; imported by all ctaus modules
`timescale 1ns / 1ps

package ctaus_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned LimitW = 31;
  localparam int unsigned DataW  = 32;

  // divider runs one quotient bit per step
  localparam int unsigned DivSteps = WordW;
  localparam int unsigned CntW     = $clog2(DivSteps);

  // queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // component reset values
  localparam logic [WordW-1:0] CompAReset = 32'd2;
  localparam logic [WordW-1:0] CompBReset = 32'd8;
  localparam logic [WordW-1:0] CompCReset = 32'd32;

  // component masks and shift amounts
  localparam logic [WordW-1:0] MaskA = 32'hFFFF_FFFE;
  localparam logic [WordW-1:0] MaskB = 32'hFFFF_FFF8;
  localparam logic [WordW-1:0] MaskC = 32'hFFFF_FFF0;

  localparam int unsigned ShAa = 13;
  localparam int unsigned ShAb = 19;
  localparam int unsigned ShAd = 12;
  localparam int unsigned ShBa = 2;
  localparam int unsigned ShBb = 25;
  localparam int unsigned ShBd = 4;
  localparam int unsigned ShCa = 3;
  localparam int unsigned ShCb = 11;
  localparam int unsigned ShCd = 17;

  // one pending reduction: combined word and its limit
  typedef struct packed {
    logic [WordW-1:0]  word;
    logic [LimitW-1:0] limit;
  } ctaus_job_t;

  // front to queue
  typedef struct packed {
    logic       push;
    ctaus_job_t job;
  } ctaus_push_t;

  // queue status toward front, back and checks
  typedef struct packed {
    logic full;
    logic empty;
  } ctaus_qstat_t;

  // back status
  typedef struct packed {
    logic pop;
    logic busy;
  } ctaus_bstat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_HOLD
  } ctaus_bk_state_e;

  // s = ((s & m) << d) ^ (((s << a) ^ s) >> b), logical shifts
  function automatic logic [WordW-1:0] taus_adv(input logic [WordW-1:0] s,
                                                input logic [WordW-1:0] m,
                                                input int unsigned a,
                                                input int unsigned b,
                                                input int unsigned d);
    logic [WordW-1:0] fb;
    fb = ((s << a) ^ s) >> b;
    return ((s & m) << d) ^ fb;
  endfunction

endpackage

// File: sv/ctaus_front.sv
// front end: takes request words and advances the three components
// depends on ctaus_pkg; pushes jobs into ctaus_queue
`timescale 1ns / 1ps

module ctaus_front
  import ctaus_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [DataW-1:0] s_axis_tdata_i,   // [30:0] limit
  input  ctaus_qstat_t     qstat_i,
  output ctaus_push_t      push_o
);

  logic [WordW-1:0] comp_a_q, comp_a_d;
  logic [WordW-1:0] comp_b_q, comp_b_d;
  logic [WordW-1:0] comp_c_q, comp_c_d;
  logic             take;

  // accept whenever the queue has room
  assign s_axis_tready_o = !qstat_i.full;
  assign take            = s_axis_tvalid_i && !qstat_i.full;

  // next component states
  always_comb begin
    comp_a_d = taus_adv(comp_a_q, MaskA, ShAa, ShAb, ShAd);
    comp_b_d = taus_adv(comp_b_q, MaskB, ShBa, ShBb, ShBd);
    comp_c_d = taus_adv(comp_c_q, MaskC, ShCa, ShCb, ShCd);
  end

  // job toward the queue
  always_comb begin
    push_o.push      = take;
    push_o.job.word  = comp_a_d ^ comp_b_d ^ comp_c_d;
    push_o.job.limit = s_axis_tdata_i[LimitW-1:0];
  end

  // component state, advanced once per accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_a_q <= CompAReset;
      comp_b_q <= CompBReset;
      comp_c_q <= CompCReset;
    end else if (take) begin
      comp_a_q <= comp_a_d;
      comp_b_q <= comp_b_d;
      comp_c_q <= comp_c_d;
    end
  end

endmodule

// File: sv/ctaus_queue.sv
// short job queue between front and back
// depends on ctaus_pkg
`timescale 1ns / 1ps

module ctaus_queue
  import ctaus_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  ctaus_push_t  push_i,
  input  logic         pop_i,
  output ctaus_job_t   job_o,
  output ctaus_qstat_t qstat_o
);

  ctaus_job_t       mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign qstat_o.full  = (cnt_q == QCntW'(QDepth));
  assign qstat_o.empty = (cnt_q == '0);
  assign do_push       = push_i.push && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign job_o         = mem_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.job;
    end
  end

endmodule

// File: sv/ctaus_back.sv
// back end: bit-serial restoring modulo and the result register
// depends on ctaus_pkg; pops jobs from ctaus_queue
`timescale 1ns / 1ps

module ctaus_back
  import ctaus_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctaus_job_t       job_i,
  input  ctaus_qstat_t     qstat_i,
  output ctaus_bstat_t     bstat_o,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [DataW-1:0] m_axis_tdata_o    // [30:0] value
);

  ctaus_bk_state_e   state_q, state_d;
  logic [WordW-1:0]  dvd_q;
  logic [LimitW-1:0] rem_q;
  logic [LimitW-1:0] lim_q;
  logic [CntW-1:0]   cnt_q;
  logic [WordW-1:0]  trial;
  logic [WordW-1:0]  diff;
  logic              ge;
  logic [LimitW-1:0] rem_nxt;
  logic              last_step;
  logic              pop;

  // one restoring step
  always_comb begin
    trial     = {rem_q, dvd_q[WordW-1]};
    ge        = (trial >= {1'b0, lim_q});
    diff      = trial - {1'b0, lim_q};
    rem_nxt   = ge ? diff[LimitW-1:0] : trial[LimitW-1:0];
    last_step = (cnt_q == CntW'(DivSteps - 1));
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!qstat_i.empty) state_d = BK_RUN;
      end
      BK_RUN: begin
        if (last_step) state_d = BK_HOLD;
      end
      BK_HOLD: begin
        if (m_axis_tready_i) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop             = 1'b0;
    m_axis_tvalid_o = 1'b0;
    bstat_o.busy    = 1'b0;
    case (state_q)
      BK_IDLE: pop = !qstat_i.empty;
      BK_RUN:  bstat_o.busy = 1'b1;
      BK_HOLD: m_axis_tvalid_o = 1'b1;
      default: pop = 1'b0;
    endcase
    bstat_o.pop    = pop;
    m_axis_tdata_o = {{(DataW - LimitW){1'b0}}, rem_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (pop) begin
        cnt_q <= '0;
      end else if (state_q == BK_RUN) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // divider datapath; a zero limit forces a zero result
  always_ff @(posedge clk_i) begin
    if (pop) begin
      dvd_q <= job_i.word;
      lim_q <= job_i.limit;
      rem_q <= '0;
    end else if (state_q == BK_RUN) begin
      dvd_q <= {dvd_q[WordW-2:0], 1'b0};
      if (last_step && (lim_q == '0)) begin
        rem_q <= '0;
      end else begin
        rem_q <= rem_nxt;
      end
    end
  end

endmodule

// File: sv/combined_tausworthe_rng.sv
// Combined three-component Tausworthe generator (taus88) with a modulo output.
// Each accepted word carries a 31-bit limit; the three 32-bit components advance
// at once, their xor is queued with the limit, and a bit-serial restoring divider
// returns the word modulo the limit (zero for a zero limit). The input side takes
// a word per cycle while the two-entry queue has room; in the back end each result
// passes through a load state, 32 divider steps of the one-bit-per-cycle divider
// and a result state, and the next word is loaded only after the result is taken.
// The result stays registered until taken.
// depends on ctaus_pkg, ctaus_front, ctaus_queue, ctaus_back and the defines header
`timescale 1ns / 1ps
`include "combined_tausworthe_rng_defines.svh"

module combined_tausworthe_rng
  import ctaus_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [DataW-1:0] s_axis_tdata_i,   // [30:0] limit
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [DataW-1:0] m_axis_tdata_o    // [30:0] value
);

  ctaus_push_t  push;
  ctaus_qstat_t qstat;
  ctaus_bstat_t bstat;
  ctaus_job_t   job;

  // request intake and component state
  ctaus_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .qstat_i         (qstat),
    .push_o          (push)
  );

  // job queue
  ctaus_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (bstat.pop),
    .job_o   (job),
    .qstat_o (qstat)
  );

  // modulo reduction and result register
  ctaus_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_i           (job),
    .qstat_i         (qstat),
    .bstat_o         (bstat),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // checks
  `CTAUS_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, push.push, !qstat.full)
  `CTAUS_ASSERT_IMP(a_no_underflow, clk_i, rst_ni, bstat.pop, !qstat.empty)
  `CTAUS_ASSERT_NXT(a_pop_starts_run, clk_i, rst_ni, bstat.pop, bstat.busy && !m_axis_tvalid_o)
  `CTAUS_ASSERT_IMP(a_busy_no_result, clk_i, rst_ni, bstat.busy, !m_axis_tvalid_o && !bstat.pop)

endmodule

// File: sim/combined_tausworthe_rng_test.sv
// self-checking bench for the combined tausworthe generator with modulo output
// drives limit words on the input stream and checks each returned value in order
// depends on ctaus_pkg and combined_tausworthe_rng
`timescale 1ns / 1ps

module combined_tausworthe_rng_test;
  import ctaus_pkg::*;

  localparam int unsigned NumRandom   = 500;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 80;

  // one row of the directed table: limit, and a value to expect when fixed
  typedef struct packed {
    logic [LimitW-1:0] limit;
    logic              fixed;
    logic [LimitW-1:0] value;
  } limit_row_t;

  localparam int unsigned NumRows = 16;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid_i = 1'b0;
  logic             s_axis_tready_o;
  logic [DataW-1:0] s_axis_tdata_i = '0;   // [30:0] limit
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 1'b0;
  logic [DataW-1:0] m_axis_tdata_o;        // [30:0] value

  // bench-side copy of the three generator components
  logic [WordW-1:0] gen_a, gen_b, gen_c;

  logic [LimitW-1:0] pending_values[$];
  int unsigned       words_sent = 0;
  int unsigned       values_checked = 0;
  int unsigned       zero_limits = 0;
  int unsigned       error_count = 0;
  int unsigned       quiet_cycles = 0;
  int unsigned       hold_left = 0;
  bit                hold_done = 1'b0;

  limit_row_t directed_rows [NumRows] = '{
    '{31'd0,          1'b1, 31'd0},
    '{31'd1,          1'b1, 31'd0},
    '{31'd2,          1'b0, 31'd0},
    '{31'd3,          1'b0, 31'd0},
    '{31'h7FFF_FFFF,  1'b0, 31'd0},
    '{31'h7FFF_FFFE,  1'b0, 31'd0},
    '{31'h4000_0000,  1'b0, 31'd0},
    '{31'h3FFF_FFFF,  1'b0, 31'd0},
    '{31'h5555_5555,  1'b0, 31'd0},
    '{31'h2AAA_AAAA,  1'b0, 31'd0},
    '{31'd7,          1'b0, 31'd0},
    '{31'd1000,       1'b0, 31'd0},
    '{31'd0,          1'b1, 31'd0},
    '{31'd1,          1'b1, 31'd0},
    '{31'h0001_0000,  1'b0, 31'd0},
    '{31'h7FFF_FFFF,  1'b0, 31'd0}
  };

  combined_tausworthe_rng u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #6 clk_i = ~clk_i;

  // one component update: masked shift-in xor shifted feedback, all logical
  function automatic logic [WordW-1:0] shift_component(input logic [WordW-1:0] s,
                                                       input logic [WordW-1:0] m,
                                                       input int unsigned fb_l,
                                                       input int unsigned fb_r,
                                                       input int unsigned keep_l);
    logic [WordW-1:0] feedback;
    feedback = ((s << fb_l) ^ s) >> fb_r;
    return ((s & m) << keep_l) ^ feedback;
  endfunction

  // advance all components and reduce their xor by the limit
  function automatic logic [LimitW-1:0] next_reduced_value(input logic [LimitW-1:0] lim);
    logic [WordW-1:0] mixed;
    gen_a = shift_component(gen_a, 32'hFFFF_FFFE, 13, 19, 12);
    gen_b = shift_component(gen_b, 32'hFFFF_FFF8, 2, 25, 4);
    gen_c = shift_component(gen_c, 32'hFFFF_FFF0, 3, 11, 17);
    mixed = gen_a ^ gen_b ^ gen_c;
    if (lim == '0) begin
      return '0;
    end
    return LimitW'(mixed % {1'b0, lim});
  endfunction

  // offer one limit word, idling at random except in the calm stretch
  task automatic send_limit(input logic [LimitW-1:0] lim, input logic fixed,
                            input logic [LimitW-1:0] fixed_value);
    logic [LimitW-1:0] want;
    @(negedge clk_i);
    while (!(words_sent >= 250 && words_sent < 350) && $urandom_range(99) < 6) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {1'b0, lim};
    do @(posedge clk_i); while (!s_axis_tready_o);
    want = next_reduced_value(lim);
    pending_values.push_back(fixed ? fixed_value : want);
    words_sent++;
    if (lim == '0) begin
      zero_limits++;
    end
  endtask

  // random limit drawn from a spread of shapes
  function automatic logic [LimitW-1:0] pick_limit();
    int unsigned k;
    k = $urandom_range(30);
    case ($urandom_range(7))
      0: return LimitW'($urandom_range(15));
      1: return LimitW'(1) << k;
      2: return (LimitW'(1) << k) - 1'b1;
      3: begin
        case ($urandom_range(3))
          0: return '0;
          1: return LimitW'(1);
          2: return '1;
          default: return {1'b0, {(LimitW-1){1'b1}}};
        endcase
      end
      4: return LimitW'($urandom_range(65535));
      default: return LimitW'($urandom());
    endcase
  endfunction

  // receiver: random stalls, one long hold, and a calm stretch
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left       <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if (!hold_done && values_checked == 60) begin
      hold_left       <= HoldCycles;
      hold_done       <= 1'b1;
      m_axis_tready_i <= 1'b0;
    end else if (values_checked >= 250 && values_checked < 350) begin
      m_axis_tready_i <= 1'b1;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= 6);
    end
  end

  // compare each returned word with the oldest pending value
  always @(posedge clk_i) begin : check_values
    logic [LimitW-1:0] want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_values.size() == 0) begin
        $display("%0t: unexpected word, got %0d", $time, m_axis_tdata_o);
        error_count++;
      end else begin
        want = pending_values.pop_front();
        if (m_axis_tdata_o !== {1'b0, want}) begin
          $display("%0t: value mismatch, expected %0d got %0d", $time, want,
                   m_axis_tdata_o);
          error_count++;
        end
      end
      values_checked++;
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // reset, directed table, random words, then drain
  initial begin
    gen_a = 32'd2;
    gen_b = 32'd8;
    gen_c = 32'd32;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < NumRows; i++) begin
      send_limit(directed_rows[i].limit, directed_rows[i].fixed, directed_rows[i].value);
    end
    for (int i = 0; i < NumRandom; i++) begin
      send_limit(pick_limit(), 1'b0, '0);
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;

    wait (pending_values.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_values.size() != 0) begin
      $display("%0t: %0d values never returned", $time, pending_values.size());
      error_count++;
    end

    $display("covered %0d limit words and %0d returned values, %0d with a zero limit,",
             words_sent, values_checked, zero_limits);
    $display("with random stalls on both sides and a %0d-cycle output hold", HoldCycles);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: combined_tausworthe_rng.f
+incdir+sv
sv/ctaus_pkg.sv
sv/ctaus_front.sv
sv/ctaus_queue.sv
sv/ctaus_back.sv
sv/combined_tausworthe_rng.sv
sim/combined_tausworthe_rng_test.sv
